// ===== design/joff_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joff_pkg
// Shared types and constants of the joined-offset to fragment lookup.
// ----------------------------------------------------------------------------
package joff_pkg;

    localparam int FRAG_DEPTH = 1024;
    localparam int TEXT_DEPTH = 1024;
    localparam int FRAG_AW    = $clog2(FRAG_DEPTH);
    localparam int TEXT_AW    = $clog2(TEXT_DEPTH);
    localparam int CNT_W      = FRAG_AW + 1;
    localparam int OFF_W      = 32;
    localparam int QLEN_W     = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    typedef logic [1:0] t_mode;
    localparam t_mode MODE_FRAG  = 2'd0;
    localparam t_mode MODE_TEXT  = 2'd1;
    localparam t_mode MODE_QUERY = 2'd2;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_FRAG_COUNT   = 2'd0;
    localparam t_cfg_idx CFG_JOINED_LEN   = 2'd1;
    localparam t_cfg_idx CFG_FORWARD_INDX = 2'd2;

    typedef struct packed {
        t_mode               mode;
        logic [FRAG_AW-1:0]  entry_index;
        logic [OFF_W-1:0]    frag_start;
        logic [TEXT_AW-1:0]  frag_text_index;
        logic [OFF_W-1:0]    frag_text_offset;
        logic [OFF_W-1:0]    text_length_value;
        logic [OFF_W-1:0]    query_offset;
        logic [QLEN_W-1:0]   query_length;
        logic                reject_straddle;
    } t_item;

    typedef struct packed {
        logic                found;
        logic                straddled;
        logic                rejected;
        logic [TEXT_AW-1:0]  text_index;
        logic [OFF_W-1:0]    text_offset;
        logic [OFF_W-1:0]    text_length;
    } t_result;

    typedef struct packed {
        logic take;
        logic probe;
        logic cmp;
        logic fetch;
        logic tlen;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic is_query;
        logic past_end;
        logic empty;
        logic match;
    } t_status;

endpackage

// ===== design/joff_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joff_in_if
// Input channel: valid/ready handshake with one load or query item.
// ----------------------------------------------------------------------------
interface joff_in_if;
    logic                                   valid;
    logic                                   ready;
    logic [1:0]                             mode;
    logic [joff_pkg::FRAG_AW-1:0]           entry_index;
    logic [joff_pkg::OFF_W-1:0]             frag_start;
    logic [joff_pkg::TEXT_AW-1:0]           frag_text_index;
    logic [joff_pkg::OFF_W-1:0]             frag_text_offset;
    logic [joff_pkg::OFF_W-1:0]             text_length_value;
    logic [joff_pkg::OFF_W-1:0]             query_offset;
    logic [joff_pkg::QLEN_W-1:0]            query_length;
    logic                                   reject_straddle;

    modport source (
        output valid, mode, entry_index, frag_start, frag_text_index, frag_text_offset,
               text_length_value, query_offset, query_length, reject_straddle,
        input  ready
    );
    modport sink (
        input  valid, mode, entry_index, frag_start, frag_text_index, frag_text_offset,
               text_length_value, query_offset, query_length, reject_straddle,
        output ready
    );
endinterface

// ===== design/joff_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joff_out_if
// Output channel: valid/ready handshake with one query result.
// ----------------------------------------------------------------------------
interface joff_out_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   found;
    logic                                   straddled;
    logic                                   rejected;
    logic [joff_pkg::TEXT_AW-1:0]           text_index;
    logic [joff_pkg::OFF_W-1:0]             text_offset;
    logic [joff_pkg::OFF_W-1:0]             text_length;

    modport source (
        output valid, found, straddled, rejected, text_index, text_offset, text_length,
        input  ready
    );
    modport sink (
        input  valid, found, straddled, rejected, text_index, text_offset, text_length,
        output ready
    );
endinterface

// ===== design/joff_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joff_ctrl
// Sequencer for load transfers and the binary search probe loop.
// ----------------------------------------------------------------------------
module joff_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  joff_pkg::t_status i_status,
    output joff_pkg::t_cmd    o_cmd
);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_PROBE = 6'b000010,
        S_CMP   = 6'b000100,
        S_FETCH = 6'b001000,
        S_TLEN  = 6'b010000,
        S_RES   = 6'b100000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   take;
    logic   slot_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign take        = i_in_valid && o_in_ready;
    assign slot_free   = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state        = r_state;
        o_cmd          = '0;
        o_cmd.take     = take;
        unique case (r_state)
            S_IDLE: begin
                if (take && i_status.is_query) n_state = S_PROBE;
            end
            S_PROBE: begin
                o_cmd.probe = 1'b1;
                if (i_status.past_end || i_status.empty) n_state = S_RES;
                else n_state = S_CMP;
            end
            S_CMP: begin
                o_cmd.cmp = 1'b1;
                if (i_status.match) n_state = S_FETCH;
                else n_state = S_PROBE;
            end
            S_FETCH: begin
                o_cmd.fetch = 1'b1;
                n_state     = S_TLEN;
            end
            S_TLEN: begin
                o_cmd.tlen = 1'b1;
                n_state    = S_RES;
            end
            S_RES: begin
                if (slot_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.out_load) n_out_valid = 1'b1;
        else if (i_out_ready) n_out_valid = 1'b0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== design/joff_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joff_datapath
// Fragment and text tables, configuration, search bounds and result register.
// ----------------------------------------------------------------------------
module joff_datapath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [joff_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [joff_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  joff_pkg::t_item                     i_item,
    input  joff_pkg::t_cmd                      i_cmd,
    output joff_pkg::t_status                   o_status,
    output joff_pkg::t_result                   o_result
);

    localparam int FAW = joff_pkg::FRAG_AW;
    localparam int TAW = joff_pkg::TEXT_AW;
    localparam int CW  = joff_pkg::CNT_W;
    localparam int OW  = joff_pkg::OFF_W;

    logic [OW-1:0]  mem_start [joff_pkg::FRAG_DEPTH];
    logic [TAW-1:0] mem_text  [joff_pkg::FRAG_DEPTH];
    logic [OW-1:0]  mem_foff  [joff_pkg::FRAG_DEPTH];
    logic [OW-1:0]  mem_tlen  [joff_pkg::TEXT_DEPTH];

    logic [CW-1:0]  r_frag_count;
    logic [OW-1:0]  r_joined_len;
    logic           r_forward;

    logic [OW-1:0]  r_off;
    logic [joff_pkg::QLEN_W-1:0] r_qlen;
    logic           r_rej_req;
    logic [CW-1:0]  r_top, r_bot, r_n;
    logic [FAW-1:0] r_elt;
    logic           r_last;
    logic [OW-1:0]  r_start_a, r_start_b;
    logic [TAW-1:0] r_text_q;
    logic [OW-1:0]  r_foff_q, r_tlen_q;
    logic [OW-1:0]  r_upper, r_lower;
    logic           r_found, r_strad;
    logic [OW-1:0]  r_fragoff, r_toff, r_tlen;
    logic [TAW-1:0] r_tidx;
    joff_pkg::t_result r_res;

    logic [CW-1:0]  n_eff;
    logic [CW-1:0]  mid;
    logic [FAW-1:0] mid_lo, mid_p1;
    logic [OW-1:0]  upper;
    logic           le, gt;
    logic [OW-1:0]  hit_end;
    logic           wr_frag, wr_text, rejected;

    assign wr_frag = i_cmd.take && (i_item.mode == joff_pkg::MODE_FRAG);
    assign wr_text = i_cmd.take && (i_item.mode == joff_pkg::MODE_TEXT);

    always_comb begin
        n_eff = r_frag_count;
        if (r_frag_count == '0) n_eff = CW'(1);
        else if (r_frag_count > CW'(joff_pkg::FRAG_DEPTH)) n_eff = CW'(joff_pkg::FRAG_DEPTH);
    end

    assign mid    = r_top + ((r_bot - r_top) >> 1);
    assign mid_lo = mid[FAW-1:0];
    assign mid_p1 = mid_lo + FAW'(1);

    assign upper   = r_last ? r_joined_len : r_start_b;
    assign le      = (r_start_a <= r_off);
    assign gt      = (upper > r_off);
    assign hit_end = r_off + OW'(r_qlen);

    assign o_status.is_query = (i_item.mode == joff_pkg::MODE_QUERY);
    assign o_status.past_end = (r_off >= r_joined_len);
    assign o_status.empty    = (r_top >= r_bot);
    assign o_status.match    = le && gt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frag_count <= CW'(1);
            r_joined_len <= OW'(1);
            r_forward    <= 1'b1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                joff_pkg::CFG_FRAG_COUNT:   r_frag_count <= i_cfg_data[CW-1:0];
                joff_pkg::CFG_JOINED_LEN:   r_joined_len <= i_cfg_data[OW-1:0];
                joff_pkg::CFG_FORWARD_INDX: r_forward    <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_frag) begin
            mem_start[i_item.entry_index] <= i_item.frag_start;
            mem_text[i_item.entry_index]  <= i_item.frag_text_index;
            mem_foff[i_item.entry_index]  <= i_item.frag_text_offset;
        end
        r_start_a <= mem_start[mid_lo];
        r_start_b <= mem_start[mid_p1];
        r_text_q  <= mem_text[r_elt];
        r_foff_q  <= mem_foff[r_elt];
    end

    always_ff @(posedge i_clk) begin
        if (wr_text) mem_tlen[i_item.entry_index[TAW-1:0]] <= i_item.text_length_value;
        r_tlen_q <= mem_tlen[r_text_q];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_off     <= i_item.query_offset;
            r_qlen    <= i_item.query_length;
            r_rej_req <= i_item.reject_straddle;
            r_top     <= '0;
            r_bot     <= n_eff;
            r_n       <= n_eff;
            r_found   <= 1'b0;
            r_strad   <= 1'b0;
        end
        if (i_cmd.probe) begin
            r_elt  <= mid_lo;
            r_last <= (mid == r_n - CW'(1));
        end
        if (i_cmd.cmp) begin
            if (le && gt) begin
                r_lower <= r_start_a;
                r_upper <= upper;
            end else if (le) begin
                r_top <= {1'b0, r_elt} + CW'(1);
            end else begin
                r_bot <= {1'b0, r_elt};
            end
        end
        if (i_cmd.fetch) begin
            r_strad   <= (hit_end > r_upper);
            r_fragoff <= r_forward ? (r_off - r_lower) : (r_upper - r_off - OW'(r_qlen));
        end
        if (i_cmd.tlen) begin
            r_found <= 1'b1;
            r_toff  <= r_fragoff + r_foff_q;
            r_tidx  <= r_text_q;
            r_tlen  <= r_tlen_q;
        end
        if (i_cmd.out_load) r_res <= o_result_next(r_found, r_strad, rejected);
    end

    assign rejected = r_found && r_strad && r_rej_req;

    function automatic joff_pkg::t_result o_result_next(input logic f, input logic s,
                                                        input logic rj);
        joff_pkg::t_result res;
        res           = '0;
        res.found     = f;
        res.straddled = f && s;
        res.rejected  = rj;
        if (f && !rj) begin
            res.text_index  = r_tidx;
            res.text_offset = r_toff;
            res.text_length = r_tlen;
        end
        return res;
    endfunction

    assign o_result = r_res;

endmodule

// ===== design/joined_offset_to_fragment_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joined_offset_to_fragment_unit
// Joined-text offset to fragment translation by binary search over a table.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel carries three kinds of items. Mode 0 loads one fragment
//   entry (start, text index, text offset), mode 1 loads one text length,
//   mode 2 is a query; mode 3 is dropped. Load the tables, sorted by start,
//   before querying them. Only a query produces a transfer on the output.
//   A load leaves the input ready for the next item. A query runs at most
//   11 search probes for 1024 fragments; each probe is a read of the
//   fragment start memory followed by a compare. An offset at or past the
//   joined length skips the search. The next item is taken as soon as the
//   result sits in the output register, so a query result may wait while
//   loads proceed. A stalled receiver holds the result; a second query then
//   waits in its result state until the output register frees. Reset clears
//   the control state and sets fragment_count, joined_length and
//   forward_index to 1; the table contents stay undefined until written.
// ----------------------------------------------------------------------------
module joined_offset_to_fragment_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [joff_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [joff_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    joff_in_if.sink                             i_in,
    joff_out_if.source                          o_out
);

    joff_pkg::t_item   item;
    joff_pkg::t_cmd    cmd;
    joff_pkg::t_status status;
    joff_pkg::t_result result;
    logic              in_ready;
    logic              out_valid;

    assign item.mode              = i_in.mode;
    assign item.entry_index       = i_in.entry_index;
    assign item.frag_start        = i_in.frag_start;
    assign item.frag_text_index   = i_in.frag_text_index;
    assign item.frag_text_offset  = i_in.frag_text_offset;
    assign item.text_length_value = i_in.text_length_value;
    assign item.query_offset      = i_in.query_offset;
    assign item.query_length      = i_in.query_length;
    assign item.reject_straddle   = i_in.reject_straddle;

    joff_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_out.ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    joff_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (item),
        .i_cmd      (cmd),
        .o_status   (status),
        .o_result   (result)
    );

    assign i_in.ready        = in_ready;
    assign o_out.valid       = out_valid;
    assign o_out.found       = result.found;
    assign o_out.straddled   = result.straddled;
    assign o_out.rejected    = result.rejected;
    assign o_out.text_index  = result.text_index;
    assign o_out.text_offset = result.text_offset;
    assign o_out.text_length = result.text_length;

endmodule

// ===== design/joff_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// joff_checker
// Port-level checks on result transfers of the fragment lookup.
// ----------------------------------------------------------------------------
module joff_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_out_valid,
    input logic                                 i_out_ready,
    input logic                                 i_found,
    input logic                                 i_straddled,
    input logic                                 i_rejected,
    input logic [joff_pkg::TEXT_AW-1:0]         i_text_index,
    input logic [joff_pkg::OFF_W-1:0]           i_text_offset,
    input logic [joff_pkg::OFF_W-1:0]           i_text_length
);

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    a_reject_implies_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_rejected |-> i_found && i_straddled)
        else $error("rejected without a straddling hit");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_found |-> !i_straddled && !i_rejected && i_text_index == '0
            && i_text_offset == '0 && i_text_length == '0)
        else $error("miss carries nonzero fields");

    a_reject_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_rejected |-> i_text_index == '0 && i_text_offset == '0
            && i_text_length == '0)
        else $error("rejected result carries translation");

endmodule

bind joined_offset_to_fragment_unit joff_checker u_joff_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_found       (o_out.found),
    .i_straddled   (o_out.straddled),
    .i_rejected    (o_out.rejected),
    .i_text_index  (o_out.text_index),
    .i_text_offset (o_out.text_offset),
    .i_text_length (o_out.text_length)
);

// ===== dv/tb_joined_offset_to_fragment_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_joined_offset_to_fragment_unit
// Self-checking bench for the joined-offset lookup. It loads sorted fragment
// and text-length tables and then sends queries under random flow control on
// both channels. A scoreboard tracks the tables and registers and works out
// each search result, which is then compared field by field with the output.
// ----------------------------------------------------------------------------
module tb_joined_offset_to_fragment_unit;

    localparam int FRAG_DEPTH = joff_pkg::FRAG_DEPTH;
    localparam int TEXT_DEPTH = joff_pkg::TEXT_DEPTH;
    localparam int FRAG_AW    = joff_pkg::FRAG_AW;
    localparam int TEXT_AW    = joff_pkg::TEXT_AW;
    localparam int CNT_W      = joff_pkg::CNT_W;
    localparam int OFF_W      = joff_pkg::OFF_W;
    localparam int QLEN_W     = joff_pkg::QLEN_W;
    localparam int CFG_DATA_W = joff_pkg::CFG_DATA_W;

    localparam joff_pkg::t_mode MODE_DROP = 2'd3;
    localparam int    ITEM_TARGET   = 1150;
    localparam int    SETTLE_CYCLES = 32;
    localparam int    HOLD_CYCLES   = 400;
    localparam int    MAX_COUNT     = 2047;

    class lookup_scoreboard;
        logic [OFF_W-1:0]   start_tab [FRAG_DEPTH];
        logic [TEXT_AW-1:0] text_tab  [FRAG_DEPTH];
        logic [OFF_W-1:0]   base_tab  [FRAG_DEPTH];
        logic [OFF_W-1:0]   tlen_tab  [TEXT_DEPTH];
        logic [CNT_W-1:0]   frag_count;
        logic [OFF_W-1:0]   joined_len;
        logic               forward;
        joff_pkg::t_result  pending_q [$];
        int                 errors;

        function new();
            frag_count = CNT_W'(1);
            joined_len = OFF_W'(1);
            forward    = 1'b1;
            errors     = 0;
        endfunction

        function void write_reg(joff_pkg::t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                joff_pkg::CFG_FRAG_COUNT:   frag_count = data[CNT_W-1:0];
                joff_pkg::CFG_JOINED_LEN:   joined_len = data[OFF_W-1:0];
                joff_pkg::CFG_FORWARD_INDX: forward    = data[0];
                default: ;
            endcase
        endfunction

        function int active_count();
            if (frag_count == '0) return 1;
            if (frag_count > CNT_W'(FRAG_DEPTH)) return FRAG_DEPTH;
            return int'(frag_count);
        endfunction

        function void note_input(joff_pkg::t_item it);
            joff_pkg::t_result res;
            int               n, lo_i, hi_i, mid;
            logic [OFF_W-1:0] lower, upper, span, pos, sum;
            res = '0;
            case (it.mode)
                joff_pkg::MODE_FRAG: begin
                    start_tab[it.entry_index] = it.frag_start;
                    text_tab[it.entry_index]  = it.frag_text_index;
                    base_tab[it.entry_index]  = it.frag_text_offset;
                end
                joff_pkg::MODE_TEXT: begin
                    tlen_tab[it.entry_index] = it.text_length_value;
                end
                joff_pkg::MODE_QUERY: begin
                    n    = active_count();
                    lo_i = 0;
                    hi_i = n;
                    if (it.query_offset < joined_len) begin
                        while (lo_i < hi_i) begin
                            mid   = lo_i + (hi_i - lo_i) / 2;
                            lower = start_tab[FRAG_AW'(mid)];
                            upper = (mid == n - 1) ? joined_len
                                                   : start_tab[FRAG_AW'(mid + 1)];
                            if (lower > it.query_offset) begin
                                hi_i = mid;
                            end else if (upper <= it.query_offset) begin
                                lo_i = mid + 1;
                            end else begin
                                sum           = it.query_offset + OFF_W'(it.query_length);
                                res.found     = 1'b1;
                                res.straddled = sum > upper;
                                if (res.straddled && it.reject_straddle) begin
                                    res.rejected = 1'b1;
                                end else begin
                                    pos = it.query_offset - lower;
                                    // mirror the position inside the fragment
                                    if (!forward) begin
                                        span = upper - lower;
                                        pos  = span - pos - 1;
                                        pos  = pos - (OFF_W'(it.query_length) - 1);
                                    end
                                    res.text_index  = text_tab[FRAG_AW'(mid)];
                                    res.text_offset = pos + base_tab[FRAG_AW'(mid)];
                                    res.text_length = tlen_tab[text_tab[FRAG_AW'(mid)]];
                                end
                                break;
                            end
                        end
                    end
                    pending_q.push_back(res);
                end
                default: ;
            endcase
        endfunction

        function void flag_field(string name, logic [OFF_W-1:0] want, logic [OFF_W-1:0] got);
            if (got !== want) begin
                errors++;
                $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            end
        endfunction

        function void check_result(joff_pkg::t_result got);
            joff_pkg::t_result want;
            if (pending_q.size() == 0) begin
                errors++;
                $display("%0t: result with none expected: expected none, actual %h",
                         $time, got);
                return;
            end
            want = pending_q.pop_front();
            flag_field("found",       OFF_W'(want.found),      OFF_W'(got.found));
            flag_field("straddled",   OFF_W'(want.straddled),  OFF_W'(got.straddled));
            flag_field("rejected",    OFF_W'(want.rejected),   OFF_W'(got.rejected));
            flag_field("text_index",  OFF_W'(want.text_index), OFF_W'(got.text_index));
            flag_field("text_offset", want.text_offset,        got.text_offset);
            flag_field("text_length", want.text_length,        got.text_length);
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    joff_pkg::t_cfg_idx    cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;

    joff_in_if  in_ch ();
    joff_out_if out_ch ();

    joined_offset_to_fragment_unit dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in       (in_ch),
        .o_out      (out_ch)
    );

    lookup_scoreboard sb = new();

    int burst_left = 0;
    int items_sent = 0;
    bit offering   = 1'b0;
    bit hold_req   = 1'b0;
    int text_pool [$];

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk) begin : result_monitor
        joff_pkg::t_result got;
        got = '{out_ch.found, out_ch.straddled, out_ch.rejected, out_ch.text_index,
                out_ch.text_offset, out_ch.text_length};
        if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            sb.check_result(got);
        end
    end

    initial begin : receiver
        int style, span, tick;
        style = 0;
        span  = 0;
        tick  = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge clk);
            // hold off long enough for the block to back up into its input
            if (hold_req) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            if (span == 0) begin
                style = $urandom_range(0, 3);
                span  = $urandom_range(20, 200);
            end
            span--;
            tick++;
            case (style)
                0:       out_ch.ready <= 1'b1;
                1:       out_ch.ready <= (tick % 4) != 0;
                2:       out_ch.ready <= 1'($urandom_range(0, 1));
                default: out_ch.ready <= (tick % 7) < 2;
            endcase
        end
    end

    initial begin : watchdog
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    function automatic joff_pkg::t_item random_item(joff_pkg::t_mode m);
        joff_pkg::t_item it;
        it.mode              = m;
        it.entry_index       = FRAG_AW'($urandom);
        it.frag_start        = $urandom;
        it.frag_text_index   = TEXT_AW'($urandom);
        it.frag_text_offset  = $urandom;
        it.text_length_value = $urandom;
        it.query_offset      = $urandom;
        it.query_length      = QLEN_W'($urandom);
        it.reject_straddle   = 1'($urandom);
        return it;
    endfunction

    function automatic int pick_text();
        return text_pool[$urandom_range(0, text_pool.size() - 1)];
    endfunction

    task automatic withdraw();
        if (offering) begin
            in_ch.valid <= 1'b0;
            offering = 1'b0;
        end
    endtask

    task automatic send_item(joff_pkg::t_item it);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                withdraw();
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(60, 250)
                                                     : $urandom_range(1, 16);
        end
        burst_left--;
        in_ch.valid             <= 1'b1;
        in_ch.mode              <= it.mode;
        in_ch.entry_index       <= it.entry_index;
        in_ch.frag_start        <= it.frag_start;
        in_ch.frag_text_index   <= it.frag_text_index;
        in_ch.frag_text_offset  <= it.frag_text_offset;
        in_ch.text_length_value <= it.text_length_value;
        in_ch.query_offset      <= it.query_offset;
        in_ch.query_length      <= it.query_length;
        in_ch.reject_straddle   <= it.reject_straddle;
        offering = 1'b1;
        do @(posedge clk); while (in_ch.ready !== 1'b1);
        sb.note_input(it);
        items_sent++;
    endtask

    task automatic drain();
        withdraw();
        burst_left = 0;
        while (sb.pending_q.size() != 0) @(posedge clk);
    endtask

    task automatic settle();
        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg_port(joff_pkg::t_cfg_idx idx, logic [CFG_DATA_W-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
        sb.write_reg(idx, data);
    endtask

    task automatic set_registers(logic [CNT_W-1:0] count, logic [OFF_W-1:0] joined,
                                 logic fwd);
        // upper bits carry noise that the block must drop
        write_reg_port(joff_pkg::CFG_FRAG_COUNT, ($urandom << CNT_W) | CFG_DATA_W'(count));
        write_reg_port(joff_pkg::CFG_JOINED_LEN, joined);
        write_reg_port(joff_pkg::CFG_FORWARD_INDX, ($urandom << 1) | CFG_DATA_W'(fwd));
        cfg_we <= 1'b0;
    endtask

    task automatic load_fragment(int idx, logic [OFF_W-1:0] start, int text,
                                 logic [OFF_W-1:0] base);
        joff_pkg::t_item it;
        it                  = random_item(joff_pkg::MODE_FRAG);
        it.entry_index      = FRAG_AW'(idx);
        it.frag_start       = start;
        it.frag_text_index  = TEXT_AW'(text);
        it.frag_text_offset = base;
        send_item(it);
    endtask

    task automatic load_text(int idx, logic [OFF_W-1:0] len);
        joff_pkg::t_item it;
        it                   = random_item(joff_pkg::MODE_TEXT);
        it.entry_index       = FRAG_AW'(idx);
        it.text_length_value = len;
        send_item(it);
        text_pool.push_back(idx);
    endtask

    task automatic query(logic [OFF_W-1:0] off, logic [QLEN_W-1:0] qlen, logic reject);
        joff_pkg::t_item it;
        it                 = random_item(joff_pkg::MODE_QUERY);
        it.query_offset    = off;
        it.query_length    = qlen;
        it.reject_straddle = reject;
        send_item(it);
    endtask

    task automatic build_table(input int n, input logic [OFF_W-1:0] first, input int stride,
                               output logic [OFF_W-1:0] joined);
        logic [OFF_W-1:0] pos;
        pos = first;
        repeat ($urandom_range(2, 5)) load_text($urandom_range(0, TEXT_DEPTH - 1), $urandom);
        for (int k = 0; k < n; k++) begin
            load_fragment(k, pos, pick_text(), $urandom);
            if (k < n - 1) begin
                pos += ($urandom_range(0, 15) == 0) ? 0 : $urandom_range(1, stride);
            end
        end
        joined = pos + $urandom_range(1, stride);
    endtask

    task automatic random_query();
        int                n, k;
        logic [OFF_W-1:0]  lower, upper, off;
        logic [QLEN_W-1:0] qlen;
        n     = sb.active_count();
        k     = $urandom_range(0, n - 1);
        lower = sb.start_tab[FRAG_AW'(k)];
        upper = (k == n - 1) ? sb.joined_len : sb.start_tab[FRAG_AW'(k + 1)];
        case ($urandom_range(0, 19))
            0:       off = $urandom_range(32'hFFFF_FFFF, sb.joined_len);
            1:       off = (sb.start_tab[0] > 0) ? $urandom_range(sb.start_tab[0] - 1, 0)
                                                 : $urandom;
            default: off = (upper > lower) ? $urandom_range(upper - 1, lower)
                                           : $urandom_range(sb.joined_len - 1, 0);
        endcase
        case ($urandom_range(0, 9))
            0:       qlen = QLEN_W'($urandom);
            1:       qlen = QLEN_W'(upper - off + $urandom_range(0, 1));
            2:       qlen = '0;
            default: qlen = QLEN_W'($urandom_range(1, 24));
        endcase
        query(off, qlen, 1'($urandom_range(0, 1)));
    endtask

    task automatic query_burst(int count);
        repeat (count) begin
            case ($urandom_range(0, 59))
                0:       send_item(random_item(MODE_DROP));
                1:       load_text($urandom_range(0, TEXT_DEPTH - 1), $urandom);
                2:       load_fragment($urandom_range(0, sb.active_count() - 1), $urandom,
                                       pick_text(), $urandom);
                3:       drain();
                default: random_query();
            endcase
        end
    endtask

    initial begin : stimulus
        logic [OFF_W-1:0] joined, first;
        logic             fwd;
        int               n, stride;
        rst_n                   <= 1'b0;
        cfg_we                  <= 1'b0;
        cfg_idx                 <= joff_pkg::CFG_FRAG_COUNT;
        cfg_data                <= '0;
        in_ch.valid             <= 1'b0;
        in_ch.mode              <= joff_pkg::MODE_FRAG;
        in_ch.entry_index       <= '0;
        in_ch.frag_start        <= '0;
        in_ch.frag_text_index   <= '0;
        in_ch.frag_text_offset  <= '0;
        in_ch.text_length_value <= '0;
        in_ch.query_offset      <= '0;
        in_ch.query_length      <= '0;
        in_ch.reject_straddle   <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // single fragment under reset settings: hits, straddles, past end
        load_text(0, 32'hFFFF_FFFF);
        load_text(TEXT_DEPTH - 1, 32'h0);
        load_text('h155, 32'h5555_5555);
        load_text('h2AA, 32'hAAAA_AAAA);
        load_fragment(0, 32'h0, TEXT_DEPTH - 1, 32'hFFFF_FFFF);
        query(32'h0, 16'd1, 1'b0);
        query(32'h0, 16'hFFFF, 1'b1);
        query(32'h0, 16'hFFFF, 1'b0);
        query(32'h0, 16'd0, 1'b0);
        query(32'h1, 16'd1, 1'b0);
        query(32'hFFFF_FFFF, 16'd1, 1'b1);
        send_item(random_item(MODE_DROP));
        settle();

        // reverse index, gap below the first fragment, wrap at the top
        set_registers(CNT_W'(4), 32'hFFFF_FFFF, 1'b0);
        load_fragment(0, 32'h10, 0, 32'h0);
        load_fragment(1, 32'h1000, 'h155, 32'h8000_0000);
        load_fragment(2, 32'h8000_0000, 'h2AA, 32'h7FFF_FFFF);
        load_fragment(3, 32'hFFFF_0000, TEXT_DEPTH - 1, 32'h1234);
        load_fragment(FRAG_DEPTH - 1, 32'hFFFF_FFFF, 'h155, 32'h0);
        query(32'h0, 16'd1, 1'b0);
        query(32'h10, 16'd1, 1'b0);
        query(32'h8000_0000, 16'd16, 1'b1);
        query(32'hFFFF_FFFE, 16'hFFFF, 1'b0);
        query(32'h0FFF, 16'd2, 1'b1);
        query(32'hFFFF_FFFE, 16'd1, 1'b1);

        fwd    = 1'b1;
        joined = 1;
        for (int phase = 0; phase < 5 || items_sent < ITEM_TARGET; phase++) begin
            settle();
            case (phase)
                0: begin
                    n = FRAG_DEPTH;
                    build_table(n, $urandom_range(0, 3), 4_000_000, joined);
                    fwd = 1'($urandom_range(0, 1));
                end
                1: begin
                    // saturating count over the full table
                    n   = MAX_COUNT;
                    fwd = !fwd;
                end
                2: begin
                    // zero count acts as a single fragment
                    n = 0;
                    build_table(1, $urandom_range(0, 100), 1000, joined);
                    fwd = 1'($urandom_range(0, 1));
                end
                default: begin
                    n = ($urandom_range(0, 4) == 0) ? $urandom_range(17, 40)
                                                    : $urandom_range(1, 16);
                    case ($urandom_range(0, 2))
                        0:       stride = 3;
                        1:       stride = 1000;
                        default: stride = 1_000_000;
                    endcase
                    first = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 50) : 0;
                    build_table(n, first, stride, joined);
                    fwd = 1'($urandom_range(0, 1));
                end
            endcase
            settle();
            set_registers(CNT_W'(n), joined, fwd);
            if (phase == 0) hold_req = 1'b1;
            query_burst((phase == 0) ? 60 : $urandom_range(15, 30));
        end
        settle();

        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/joff_pkg.sv
design/joff_in_if.sv
design/joff_out_if.sv
design/joff_ctrl.sv
design/joff_datapath.sv
design/joined_offset_to_fragment_unit.sv
design/joff_checker.sv
dv/tb_joined_offset_to_fragment_unit.sv
